>>> rtl/core/lcgj_pkg.sv
// lcgj_pkg: constants, codes and state type for the lcg jump-ahead unit
// no dependencies; imported by the interfaces and lcg_jump_ahead_unit_core
package lcgj_pkg;

  localparam int unsigned SeedW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned ModeW = 2;

  // operation codes carried in the mode field
  localparam logic [ModeW-1:0] MODE_LOAD = 2'd0;
  localparam logic [ModeW-1:0] MODE_FWD  = 2'd1;
  localparam logic [ModeW-1:0] MODE_BWD  = 2'd2;

  // generator step s' = s * mult + inc, and its inverse
  localparam logic [SeedW-1:0] FWD_MULT = 32'h0003_43FD;
  localparam logic [SeedW-1:0] FWD_INC  = 32'h0026_9EC3;
  localparam logic [SeedW-1:0] BWD_MULT = 32'hB9B3_3155;
  localparam logic [SeedW-1:0] BWD_INC  = 32'hA170_F641;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINAL
  } lcgj_state_t;

endpackage

>>> rtl/core/lcgj_in_if.sv
// lcgj_in_if: command channel of the jump-ahead unit (valid/ready plus payload)
// depends on lcgj_pkg for field widths
interface lcgj_in_if
  import lcgj_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [SeedW-1:0] load_value;
  logic [SeedW-1:0] step_count;

  modport source (output valid, output mode, output load_value, output step_count,
                  input ready);
  modport sink   (input valid, input mode, input load_value, input step_count,
                  output ready);
endinterface

>>> rtl/core/lcgj_out_if.sv
// lcgj_out_if: result channel of the jump-ahead unit (valid/ready plus payload)
// depends on lcgj_pkg for field widths
interface lcgj_out_if
  import lcgj_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SeedW-1:0] seed_out;
  logic [FracW-1:0] fraction;

  modport source (output valid, output seed_out, output fraction, input ready);
  modport sink   (input valid, input seed_out, input fraction, output ready);
endinterface

>>> rtl/core/lcg_jump_ahead_unit_core.sv
// lcg_jump_ahead_unit_core: seed register with load and forward/backward jump-ahead
// depends on lcgj_pkg, lcgj_in_if and lcgj_out_if
//
// usage:
//   in_ch  carries commands: mode (load, forward, backward), load_value, step_count.
//          one beat is taken while the unit is idle; in_ch.ready is low while it works.
//   out_ch carries one beat per command: seed_out, the new seed, and fraction,
//          its upper 16 bits read as a 0.16 fraction.
//   a jump runs square-and-multiply over the step count, one count bit per cycle
//   through a bank of four 32x32 low-half multipliers, and stops after the highest
//   set bit. a final step then reuses a multiplier to apply the jump to the seed.
//   a load, an unused mode or a zero count skips the count walk and goes straight
//   to the final step.
//   a new command is taken only once the result is registered, so back to back
//   jumps do not overlap.
//   a stalled result sits in the output register; the next command is still taken,
//   and its result waits in the final cycle until the output register is free.
//   reset clears the seed to zero and empties the output register.
module lcg_jump_ahead_unit_core
  import lcgj_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lcgj_in_if.sink    in_ch,
  lcgj_out_if.source out_ch
);

  lcgj_state_t state_r, state_nxt;

  logic [SeedW-1:0] seed_r, seed_nxt;
  logic [SeedW-1:0] n_r, n_nxt;
  logic [SeedW-1:0] cur_m_r, cur_m_nxt;
  logic [SeedW-1:0] cur_c_r, cur_c_nxt;
  logic [SeedW-1:0] acc_m_r, acc_m_nxt;
  logic [SeedW-1:0] acc_c_r, acc_c_nxt;
  logic [SeedW-1:0] out_seed_r, out_seed_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_fire;
  logic [SeedW-1:0] mul0_b;
  logic [SeedW-1:0] p_am, p_ac, p_cc, p_mm;
  logic [SeedW-1:0] cur_m_inc;
  logic [SeedW-1:0] jumped;

  assign in_fire = in_ch.valid && in_ch.ready;

  // shared multiplier bank, low 32 bits only; mul0 applies the jump in the final cycle
  assign mul0_b    = (state_r == ST_FINAL) ? seed_r : cur_m_r;
  assign cur_m_inc = cur_m_r + 32'd1;
  assign p_am      = acc_m_r * mul0_b;
  assign p_ac      = acc_c_r * cur_m_r;
  assign p_cc      = cur_m_inc * cur_c_r;
  assign p_mm      = cur_m_r * cur_m_r;
  assign jumped    = p_am + acc_c_r;

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    n_nxt         = n_r;
    cur_m_nxt     = cur_m_r;
    cur_c_nxt     = cur_c_r;
    acc_m_nxt     = acc_m_r;
    acc_c_nxt     = acc_c_r;
    out_seed_nxt  = out_seed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    in_ch.ready   = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // identity jump unless a real move follows
          acc_m_nxt = 32'd1;
          acc_c_nxt = '0;
          n_nxt     = in_ch.step_count;
          state_nxt = ST_FINAL;
          priority if (in_ch.mode == MODE_LOAD) begin
            seed_nxt = in_ch.load_value;
          end else if (in_ch.mode == MODE_FWD) begin
            cur_m_nxt = FWD_MULT;
            cur_c_nxt = FWD_INC;
            if (in_ch.step_count != '0) state_nxt = ST_STEP;
          end else if (in_ch.mode == MODE_BWD) begin
            cur_m_nxt = BWD_MULT;
            cur_c_nxt = BWD_INC;
            if (in_ch.step_count != '0) state_nxt = ST_STEP;
          end else begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_STEP: begin
        if (n_r[0]) begin
          acc_m_nxt = p_am;
          acc_c_nxt = p_ac + cur_c_r;
        end
        cur_c_nxt = p_cc;
        cur_m_nxt = p_mm;
        n_nxt     = n_r >> 1;
        // no set bits left above this one
        if ((n_r >> 1) == '0) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (!out_valid_r || out_ch.ready) begin
          seed_nxt      = jumped;
          out_seed_nxt  = jumped;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    cur_m_r    <= cur_m_nxt;
    cur_c_r    <= cur_c_nxt;
    acc_m_r    <= acc_m_nxt;
    acc_c_r    <= acc_c_nxt;
    out_seed_r <= out_seed_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.seed_out = out_seed_r;
  assign out_ch.fraction = out_seed_r[SeedW-1 -: FracW];

  // a load lands in the seed register right after its beat
  a_load_seed: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.mode == MODE_LOAD |=> seed_r == $past(in_ch.load_value))
    else $error("load beat did not set the seed");

  // the count walk only runs while set bits remain
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> n_r != '0)
    else $error("jump loop running on an empty count");

  // each loop cycle consumes exactly one count bit
  a_step_shift: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |=> n_r == ($past(n_r) >> 1))
    else $error("count not shifted by one bit per cycle");

  // a new result is only registered from the final cycle
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINAL)
    else $error("result raised outside the final cycle");

  // no second command while the first is in flight
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("command taken while busy");

endmodule
